/* hw/rtl/tws_pkg.sv */
// ----------------------------------------------------------------------------
// tws_pkg
// Shared widths, types and register codes of the wireframe edge shader.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int CoordW  = 21;            // signed Q10.10 coordinate
  localparam int VecW    = 3 * CoordW;    // packed x, y, z
  localparam int DiffW   = CoordW + 1;    // coordinate difference
  localparam int SqW     = 2 * DiffW;     // squared length, Q24.20
  localparam int HalfW   = SqW / 2;       // partial product operand
  localparam int NumW    = 2 * SqW;       // numerator of the distance division
  localparam int DistW   = SqW / 2;       // distance, Q12.10
  localparam int EwW     = 20;            // edge width
  localparam int TwW     = 16;            // transition width
  localparam int TW      = 16;            // smoothstep parameter t, Q0.16
  localparam int ChanW   = 16;            // one colour channel
  localparam int ColorW  = 3 * ChanW;
  localparam int AlphaW  = 17;            // Q0.16 with 1.0 exact
  localparam int AddrW   = 5;
  localparam int DataW   = 64;
  localparam int RegIdxLsb = 3;

  localparam logic [AlphaW-1:0] AlphaOneVal = 17'h1_0000;

  localparam logic [1:0] RegEdgeColor     = 2'd0;
  localparam logic [1:0] RegInteriorColor = 2'd1;
  localparam logic [1:0] RegEdgeWidth     = 2'd2;
  localparam logic [1:0] RegTransWidth    = 2'd3;

  typedef enum logic [1:0] {
    AlphaZero,
    AlphaOne,
    AlphaRamp
  } alpha_mode_e;

  typedef struct packed {
    logic [ColorW-1:0] edge_color;
    logic [ColorW-1:0] interior_color;
    logic [EwW-1:0]    edge_width;
    logic [EwW-1:0]    lo;
    logic [EwW-1:0]    span;
  } cfg_t;

endpackage

/* hw/rtl/tws_div_pipe.sv */
// ----------------------------------------------------------------------------
// tws_div_pipe
// Pipelined restoring divider, one quotient bit per stage.
// The numerator must be below den << QW, so the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module tws_div_pipe #(
  parameter int QW = 16,
  parameter int DW = 20,
  parameter int SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [QW+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quot_o,
  output logic [SW-1:0]    side_o
);

  logic          valid_q [QW];
  logic [DW-1:0] rem_q   [QW];
  logic [QW-1:0] nq_q    [QW];
  logic [DW-1:0] den_q   [QW];
  logic [SW-1:0] side_q  [QW];

  logic          valid_in [QW];
  logic [DW-1:0] rem_in   [QW];
  logic [QW-1:0] nq_in    [QW];
  logic [DW-1:0] den_in   [QW];
  logic [SW-1:0] side_in  [QW];
  logic [DW:0]   shifted  [QW];
  logic [DW:0]   diff     [QW];
  logic          ge       [QW];
  logic [DW-1:0] rem_d    [QW];
  logic [QW-1:0] nq_d     [QW];

  always_comb begin
    valid_in[0] = valid_i;
    rem_in[0]   = num_i[QW+DW-1:QW];
    nq_in[0]    = num_i[QW-1:0];
    den_in[0]   = den_i;
    side_in[0]  = side_i;
    for (int s = 1; s < QW; s++) begin
      valid_in[s] = valid_q[s-1];
      rem_in[s]   = rem_q[s-1];
      nq_in[s]    = nq_q[s-1];
      den_in[s]   = den_q[s-1];
      side_in[s]  = side_q[s-1];
    end
    // The register nq holds the numerator bits still to come at the top and
    // the quotient bits found so far at the bottom.
    for (int s = 0; s < QW; s++) begin
      shifted[s] = {rem_in[s], nq_in[s][QW-1]};
      diff[s]    = shifted[s] - {1'b0, den_in[s]};
      ge[s]      = shifted[s] >= {1'b0, den_in[s]};
      rem_d[s]   = ge[s] ? diff[s][DW-1:0] : shifted[s][DW-1:0];
      nq_d[s]    = {nq_in[s][QW-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QW; s++) valid_q[s] <= 1'b0;
    end else begin
      for (int s = 0; s < QW; s++) valid_q[s] <= valid_in[s];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < QW; s++) begin
      rem_q[s]  <= rem_d[s];
      nq_q[s]   <= nq_d[s];
      den_q[s]  <= den_in[s];
      side_q[s] <= side_in[s];
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quot_o  = nq_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

/* hw/rtl/tws_edge.sv */
// ----------------------------------------------------------------------------
// tws_edge
// Squared distance from the hit point to the line of each triangle edge.
// Six arithmetic stages build the exact numerator, then a divider per edge.
// ----------------------------------------------------------------------------
module tws_edge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic                              has_tri_i,
  input  logic [tws_pkg::VecW-1:0]          vertex_a_i,
  input  logic [tws_pkg::VecW-1:0]          vertex_b_i,
  input  logic [tws_pkg::VecW-1:0]          vertex_c_i,
  input  logic [tws_pkg::VecW-1:0]          hit_point_i,
  output logic                              valid_o,
  output logic                              has_tri_o,
  output logic [2:0][tws_pkg::SqW-1:0]      dist2_o
);
  import tws_pkg::*;

  logic [2:0][VecW-1:0] verts;
  assign verts[0] = vertex_a_i;
  assign verts[1] = vertex_b_i;
  assign verts[2] = vertex_c_i;

  logic [5:0] valid_q;
  logic [5:0] tri_q;

  // Stage 1: edge direction d and point offset w.
  logic signed [DiffW-1:0] d_d [3][3];
  logic signed [DiffW-1:0] w_d [3][3];
  logic signed [DiffW-1:0] d_q [3][3];
  logic signed [DiffW-1:0] w_q [3][3];

  always_comb begin
    logic signed [CoordW-1:0] cur_c;
    logic signed [CoordW-1:0] nxt_c;
    logic signed [CoordW-1:0] hit_c;
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        cur_c = verts[e][(2-k)*CoordW +: CoordW];
        nxt_c = verts[(e == 2) ? 0 : e + 1][(2-k)*CoordW +: CoordW];
        hit_c = hit_point_i[(2-k)*CoordW +: CoordW];
        d_d[e][k] = DiffW'(nxt_c) - DiffW'(cur_c);
        w_d[e][k] = DiffW'(hit_c) - DiffW'(cur_c);
      end
    end
  end

  // Stage 2: component products.
  logic signed [SqW-1:0] dd_p_q [3][3];
  logic signed [SqW-1:0] ww_p_q [3][3];
  logic signed [SqW-1:0] dw_p_q [3][3];

  // Stage 3: sums; a degenerate edge turns into ww / 1.
  logic [SqW-1:0] den3_d [3];
  logic [SqW-1:0] ww3_d  [3];
  logic [SqW-1:0] adw3_d [3];
  logic [SqW-1:0] den3_q [3];
  logic [SqW-1:0] ww3_q  [3];
  logic [SqW-1:0] adw3_q [3];

  always_comb begin
    logic [SqW-1:0]          dd_s;
    logic signed [SqW+1:0]   dw_s;
    logic [SqW+1:0]          dw_abs;
    for (int e = 0; e < 3; e++) begin
      dd_s = dd_p_q[e][0] + dd_p_q[e][1] + dd_p_q[e][2];
      ww3_d[e] = ww_p_q[e][0] + ww_p_q[e][1] + ww_p_q[e][2];
      dw_s = (SqW+2)'(dw_p_q[e][0]) + (SqW+2)'(dw_p_q[e][1]) + (SqW+2)'(dw_p_q[e][2]);
      dw_abs = dw_s[SqW+1] ? -dw_s : dw_s;
      if (dd_s == '0) begin
        den3_d[e] = SqW'(1);
        adw3_d[e] = '0;
      end else begin
        den3_d[e] = dd_s;
        adw3_d[e] = dw_abs[SqW-1:0];
      end
    end
  end

  // Stage 4: partial products of ww*dd and dw*dw.
  logic [SqW-1:0] wd_hh_q [3];
  logic [SqW-1:0] wd_hl_q [3];
  logic [SqW-1:0] wd_lh_q [3];
  logic [SqW-1:0] wd_ll_q [3];
  logic [SqW-1:0] aa_hh_q [3];
  logic [SqW-1:0] aa_hl_q [3];
  logic [SqW-1:0] aa_ll_q [3];
  logic [SqW-1:0] den4_q  [3];

  // Stage 5: the two products; stage 6: their difference.
  logic [NumW-1:0] p1_q   [3];
  logic [NumW-1:0] p2_q   [3];
  logic [SqW-1:0]  den5_q [3];
  logic [NumW-1:0] num_q  [3];
  logic [SqW-1:0]  den6_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tri_q <= {tri_q[4:0], has_tri_i};
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        d_q[e][k]    <= d_d[e][k];
        w_q[e][k]    <= w_d[e][k];
        dd_p_q[e][k] <= d_q[e][k] * d_q[e][k];
        ww_p_q[e][k] <= w_q[e][k] * w_q[e][k];
        dw_p_q[e][k] <= d_q[e][k] * w_q[e][k];
      end
      den3_q[e] <= den3_d[e];
      ww3_q[e]  <= ww3_d[e];
      adw3_q[e] <= adw3_d[e];

      wd_hh_q[e] <= ww3_q[e][SqW-1:HalfW] * den3_q[e][SqW-1:HalfW];
      wd_hl_q[e] <= ww3_q[e][SqW-1:HalfW] * den3_q[e][HalfW-1:0];
      wd_lh_q[e] <= ww3_q[e][HalfW-1:0]   * den3_q[e][SqW-1:HalfW];
      wd_ll_q[e] <= ww3_q[e][HalfW-1:0]   * den3_q[e][HalfW-1:0];
      aa_hh_q[e] <= adw3_q[e][SqW-1:HalfW] * adw3_q[e][SqW-1:HalfW];
      aa_hl_q[e] <= adw3_q[e][SqW-1:HalfW] * adw3_q[e][HalfW-1:0];
      aa_ll_q[e] <= adw3_q[e][HalfW-1:0]   * adw3_q[e][HalfW-1:0];
      den4_q[e]  <= den3_q[e];

      p1_q[e] <= {wd_hh_q[e], wd_ll_q[e]}
               + ((NumW'(wd_hl_q[e]) + NumW'(wd_lh_q[e])) << HalfW);
      p2_q[e] <= {aa_hh_q[e], aa_ll_q[e]} + (NumW'(aa_hl_q[e]) << (HalfW + 1));
      den5_q[e] <= den4_q[e];

      num_q[e]  <= p1_q[e] - p2_q[e];
      den6_q[e] <= den5_q[e];
    end
  end

  logic [2:0] div_valid;
  logic [2:0] div_tri;

  for (genvar e = 0; e < 3; e++) begin : g_div
    tws_div_pipe #(
      .QW(SqW),
      .DW(SqW),
      .SW(1)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_q[5]),
      .num_i   (num_q[e]),
      .den_i   (den6_q[e]),
      .side_i  (tri_q[5]),
      .valid_o (div_valid[e]),
      .quot_o  (dist2_o[e]),
      .side_o  (div_tri[e])
    );
  end

  // The three dividers run in lock step; all carry the same control bits.
  assign valid_o   = div_valid[0] & div_valid[1] & div_valid[2];
  assign has_tri_o = div_tri[0];

endmodule

/* hw/rtl/tws_isqrt.sv */
// ----------------------------------------------------------------------------
// tws_isqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tws_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       has_tri_i,
  input  logic [tws_pkg::SqW-1:0]    val_i,
  output logic                       valid_o,
  output logic                       has_tri_o,
  output logic [tws_pkg::DistW-1:0]  root_o
);
  import tws_pkg::*;

  localparam int RemW = DistW + 2;

  logic             valid_q [DistW];
  logic             tri_q   [DistW];
  logic [RemW-1:0]  rem_q   [DistW];
  logic [DistW-1:0] root_q  [DistW];
  logic [SqW-1:0]   val_q   [DistW];

  logic             valid_in [DistW];
  logic             tri_in   [DistW];
  logic [RemW-1:0]  rem_in   [DistW];
  logic [DistW-1:0] root_in  [DistW];
  logic [SqW-1:0]   val_in   [DistW];
  logic [RemW+1:0]  r2       [DistW];
  logic [RemW+1:0]  trial    [DistW];
  logic             ge       [DistW];
  logic [RemW+1:0]  rdiff    [DistW];

  always_comb begin
    valid_in[0] = valid_i;
    tri_in[0]   = has_tri_i;
    rem_in[0]   = '0;
    root_in[0]  = '0;
    val_in[0]   = val_i;
    for (int s = 1; s < DistW; s++) begin
      valid_in[s] = valid_q[s-1];
      tri_in[s]   = tri_q[s-1];
      rem_in[s]   = rem_q[s-1];
      root_in[s]  = root_q[s-1];
      val_in[s]   = val_q[s-1];
    end
    // Bring down the next two bits and try the root with a one appended.
    for (int s = 0; s < DistW; s++) begin
      r2[s]    = {rem_in[s], val_in[s][SqW-1:SqW-2]};
      trial[s] = {2'b00, root_in[s], 2'b01};
      ge[s]    = r2[s] >= trial[s];
      rdiff[s] = r2[s] - trial[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DistW; s++) valid_q[s] <= 1'b0;
    end else begin
      for (int s = 0; s < DistW; s++) valid_q[s] <= valid_in[s];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DistW; s++) begin
      tri_q[s]  <= tri_in[s];
      rem_q[s]  <= ge[s] ? rdiff[s][RemW-1:0] : r2[s][RemW-1:0];
      root_q[s] <= {root_in[s][DistW-2:0], ge[s]};
      val_q[s]  <= {val_in[s][SqW-3:0], 2'b00};
    end
  end

  assign valid_o   = valid_q[DistW-1];
  assign has_tri_o = tri_q[DistW-1];
  assign root_o    = root_q[DistW-1];

endmodule

/* hw/rtl/tws_shade.sv */
// ----------------------------------------------------------------------------
// tws_shade
// Smoothstep weight from the edge distance and the colour blend.
// ----------------------------------------------------------------------------
module tws_shade (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tws_pkg::cfg_t              cfg_i,
  input  logic                       valid_i,
  input  logic                       has_tri_i,
  input  logic [tws_pkg::DistW-1:0]  dist_i,
  output logic                       valid_o,
  output logic [tws_pkg::ChanW-1:0]  red_o,
  output logic [tws_pkg::ChanW-1:0]  green_o,
  output logic [tws_pkg::ChanW-1:0]  blue_o
);
  import tws_pkg::*;

  localparam logic [TW+1:0] ThreeQ16 = 18'h3_0000;

  // Stage 1: classify the distance against the ramp.
  alpha_mode_e mode_d, mode_q;
  logic [EwW-1:0] diff_q;
  logic           s1_valid_q;

  always_comb begin
    if (!has_tri_i || dist_i >= DistW'(cfg_i.edge_width)) begin
      mode_d = AlphaOne;
    end else if (dist_i <= DistW'(cfg_i.lo)) begin
      mode_d = AlphaZero;
    end else begin
      mode_d = AlphaRamp;
    end
  end

  // Ramp parameter t = (dist - lo) / (hi - lo) in Q0.16.
  logic          dv_valid;
  logic [TW-1:0] t_quot;
  logic [1:0]    dv_mode;

  tws_div_pipe #(
    .QW(TW),
    .DW(EwW),
    .SW(2)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .num_i   ({diff_q, {TW{1'b0}}}),
    .den_i   (cfg_i.span),
    .side_i  (mode_q),
    .valid_o (dv_valid),
    .quot_o  (t_quot),
    .side_o  (dv_mode)
  );

  logic          t2_valid_q;
  alpha_mode_e   t2_mode_q;
  logic [TW-1:0] t_q;
  logic [TW-1:0] t2_q;
  logic [2*TW-1:0] tt;

  assign tt = t_quot * t_quot;

  logic              a_valid_q;
  logic [AlphaW-1:0] alpha_d, alpha_q;
  logic [2*TW+1:0]   ramp;

  assign ramp = t2_q * (ThreeQ16 - {1'b0, t_q, 1'b0});

  always_comb begin
    unique case (t2_mode_q)
      AlphaZero: alpha_d = '0;
      AlphaRamp: alpha_d = ramp[TW +: AlphaW];
      default:   alpha_d = AlphaOneVal;
    endcase
  end

  // Blend: edge * (1 - alpha) + interior * alpha, rounded.
  logic                m_valid_q;
  logic [ChanW+AlphaW-1:0] ep_q [3];
  logic [ChanW+AlphaW-1:0] ip_q [3];
  logic [ChanW+AlphaW:0]   sum  [3];
  logic [ChanW-1:0]        chan_d [3];
  logic [ChanW-1:0]        chan_q [3];
  logic                    o_valid_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = (ChanW+AlphaW+1)'(ep_q[ch]) + (ChanW+AlphaW+1)'(ip_q[ch])
              + (ChanW+AlphaW+1)'(AlphaOneVal >> 1);
      chan_d[ch] = sum[ch][TW +: ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
      a_valid_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      t2_valid_q <= dv_valid;
      a_valid_q  <= t2_valid_q;
      m_valid_q  <= a_valid_q;
      o_valid_q  <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    diff_q    <= dist_i[EwW-1:0] - cfg_i.lo;
    t2_mode_q <= alpha_mode_e'(dv_mode);
    t_q       <= t_quot;
    t2_q      <= tt[2*TW-1:TW];
    alpha_q   <= alpha_d;
    for (int ch = 0; ch < 3; ch++) begin
      ep_q[ch] <= cfg_i.edge_color[(2-ch)*ChanW +: ChanW] * (AlphaOneVal - alpha_q);
      ip_q[ch] <= cfg_i.interior_color[(2-ch)*ChanW +: ChanW] * alpha_q;
      chan_q[ch] <= chan_d[ch];
    end
  end

  assign valid_o = o_valid_q;
  assign red_o   = chan_q[0];
  assign green_o = chan_q[1];
  assign blue_o  = chan_q[2];

endmodule

/* hw/rtl/tws_cfg.sv */
// ----------------------------------------------------------------------------
// tws_cfg
// Register file behind the APB port, with the derived ramp bounds.
// ----------------------------------------------------------------------------
module tws_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tws_pkg::AddrW-1:0]   paddr,
  input  logic [tws_pkg::DataW-1:0]   pwdata,
  output logic [tws_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output tws_pkg::cfg_t               cfg_o
);
  import tws_pkg::*;

  logic [ColorW-1:0] edge_color_q;
  logic [ColorW-1:0] interior_color_q;
  logic [EwW-1:0]    edge_width_q;
  logic [TwW-1:0]    trans_width_q;
  logic [EwW-1:0]    lo_q;
  logic [EwW-1:0]    span_q;
  logic [1:0]        reg_idx;
  logic              wr_en;
  logic [EwW+TwW:0]  lo_prod;

  assign reg_idx = paddr[AddrW-1:RegIdxLsb];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign lo_prod = edge_width_q * ((TwW+1)'(AlphaOneVal) - {1'b0, trans_width_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_color_q     <= '0;
      interior_color_q <= 48'h7FFF_8000_0000;
      edge_width_q     <= 20'd1024;
      trans_width_q    <= 16'h8000;
      lo_q             <= 20'd512;
      span_q           <= 20'd512;
    end else begin
      if (wr_en) begin
        unique case (reg_idx)
          RegEdgeColor:     edge_color_q     <= pwdata[ColorW-1:0];
          RegInteriorColor: interior_color_q <= pwdata[ColorW-1:0];
          RegEdgeWidth:     edge_width_q     <= pwdata[EwW-1:0];
          default:          trans_width_q    <= pwdata[TwW-1:0];
        endcase
      end
      // The bounds are registered from the registers and follow them in the next cycle.
      lo_q   <= lo_prod[TwW +: EwW];
      span_q <= edge_width_q - lo_prod[TwW +: EwW];
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegEdgeColor:     prdata = DataW'(edge_color_q);
      RegInteriorColor: prdata = DataW'(interior_color_q);
      RegEdgeWidth:     prdata = DataW'(edge_width_q);
      default:          prdata = DataW'(trans_width_q);
    endcase
  end

  assign cfg_o.edge_color     = edge_color_q;
  assign cfg_o.interior_color = interior_color_q;
  assign cfg_o.edge_width     = edge_width_q;
  assign cfg_o.lo             = lo_q;
  assign cfg_o.span           = span_q;

endmodule

/* hw/rtl/triangle_wireframe_edge_shade.sv */
// ----------------------------------------------------------------------------
// triangle_wireframe_edge_shade
// Shades a ray hit by its distance to the nearest triangle edge.
// ----------------------------------------------------------------------------
// The block takes one word per clock and never raises busy: every word
// pulsed in on start returns as one colour word on done_o exactly 95 cycles
// later, in order, and the receiver must take it in that cycle. The latency
// is set by the 44-stage divider for the squared edge distances, the
// 22-stage square root and the 16-stage divider for the smoothstep ramp.
// Registers may be written only while no word is in flight.
module triangle_wireframe_edge_shade (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         has_triangle_i,
  input  logic [tws_pkg::VecW-1:0]     vertex_a_i,
  input  logic [tws_pkg::VecW-1:0]     vertex_b_i,
  input  logic [tws_pkg::VecW-1:0]     vertex_c_i,
  input  logic [tws_pkg::VecW-1:0]     hit_point_i,
  output logic                         done_o,
  output logic [tws_pkg::ChanW-1:0]    red_o,
  output logic [tws_pkg::ChanW-1:0]    green_o,
  output logic [tws_pkg::ChanW-1:0]    blue_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tws_pkg::AddrW-1:0]    paddr,
  input  logic [tws_pkg::DataW-1:0]    pwdata,
  output logic [tws_pkg::DataW-1:0]    prdata,
  output logic                         pready
);
  import tws_pkg::*;

  cfg_t cfg;

  tws_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy = 1'b0;

  logic                 accept;
  logic                 e_valid;
  logic                 e_tri;
  logic [2:0][SqW-1:0]  dist2;

  assign accept = start && !busy;

  tws_edge u_edge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .has_tri_i   (has_triangle_i),
    .vertex_a_i  (vertex_a_i),
    .vertex_b_i  (vertex_b_i),
    .vertex_c_i  (vertex_c_i),
    .hit_point_i (hit_point_i),
    .valid_o     (e_valid),
    .has_tri_o   (e_tri),
    .dist2_o     (dist2)
  );

  // Two stages pick the smallest of the three squared distances.
  logic           m1_valid_q, m2_valid_q;
  logic           m1_tri_q, m2_tri_q;
  logic [SqW-1:0] m1_min_q, m1_c_q, m2_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
    end else begin
      m1_valid_q <= e_valid;
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_tri_q <= e_tri;
    m1_min_q <= (dist2[1] < dist2[0]) ? dist2[1] : dist2[0];
    m1_c_q   <= dist2[2];
    m2_tri_q <= m1_tri_q;
    m2_min_q <= (m1_c_q < m1_min_q) ? m1_c_q : m1_min_q;
  end

  logic             r_valid;
  logic             r_tri;
  logic [DistW-1:0] edge_dist;

  tws_isqrt u_isqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (m2_valid_q),
    .has_tri_i (m2_tri_q),
    .val_i     (m2_min_q),
    .valid_o   (r_valid),
    .has_tri_o (r_tri),
    .root_o    (edge_dist)
  );

  tws_shade u_shade (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (r_valid),
    .has_tri_i (r_tri),
    .dist_i    (edge_dist),
    .valid_o   (done_o),
    .red_o     (red_o),
    .green_o   (green_o),
    .blue_o    (blue_o)
  );

endmodule
